@@ design/cps_pkg.sv @@
// Shared types and constants for the capture period statistics unit.
// Holds the input and report item layouts and the per-channel state record.
// No dependencies.
`timescale 1ns / 1ps

package cps_pkg;

    localparam logic [1:0] CMD_OVERFLOW = 2'd0;
    localparam logic [1:0] CMD_EDGE     = 2'd1;
    localparam logic [1:0] CMD_FINISH   = 2'd2;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] NS_PER_TICK_RESET = 32'd819200;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        channel;
        logic [31:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic        report_channel;
        logic [31:0] edges_seen;
        logic [31:0] overflows_seen;
        logic [31:0] periods_seen;
        logic [47:0] min_period;
        logic [47:0] max_period;
        logic [47:0] mean_period;
        logic [47:0] stddev_period;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        have_prev;
        logic [31:0] prev_stamp;
        logic [31:0] wraps;
        logic [31:0] edges;
        logic [31:0] overflows;
        logic [31:0] periods;
        logic [47:0] mean;
        logic [63:0] m2;
        logic [47:0] least;
        logic [47:0] greatest;
    } chan_state_t;

    localparam chan_state_t CHAN_STATE_RESET = '{
        have_prev:  1'b0,
        prev_stamp: 32'd0,
        wraps:      32'd0,
        edges:      32'd0,
        overflows:  32'd0,
        periods:    32'd0,
        mean:       48'd0,
        m2:         64'd0,
        least:      MAX48,
        greatest:   48'd0
    };

    function automatic logic [31:0] inc_sat(input logic [31:0] v);
        inc_sat = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

@@ design/capture_period_statistics_unit.sv @@
// Capture period statistics unit: top level and complete datapath.
// Depends on cps_pkg for item layouts, the channel state record and commands.
`timescale 1ns / 1ps

// Timer-capture period statistics, one item at a time. An overflow item bumps
// the wrap and overflow counters of every channel in a read-modify-write sweep.
// An edge item extends the timestamp with the pending wraps, scales the period
// to ns Q32.16 with a 32x32 multiplier used twice, updates the Welford mean
// through a 64-step serial divider and M2 through four 24x24 partial products;
// a channel's first edge only counts the edge and records its stamp.
// A finish item reports channels 0 and 1 (those that exist); each report with
// two or more periods takes the 64-step divider and a 40-step square root,
// then all channel state is cleared at once. The input is taken again while
// the last report still waits in the output register. The per-channel state
// sits in one synchronous memory with valid bits.
module capture_period_statistics_unit #(
    parameter int CHANNEL_COUNT = 2,
    parameter int STAMP_BITS    = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cps_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cps_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    import cps_pkg::*;

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int NREP = (CHANNEL_COUNT < 2) ? CHANNEL_COUNT : 2;
    localparam logic [31:0] STAMP_MASK = 32'hFFFF_FFFF >> (32 - STAMP_BITS);
    localparam logic [CH_W-1:0] LAST_CH  = CH_W'(CHANNEL_COUNT - 1);
    localparam logic [CH_W-1:0] LAST_REP = CH_W'(NREP - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_OVF_RD, ST_OVF_WR, ST_EDGE_RD, ST_EDGE_CALC, ST_MUL_LO,
        ST_MUL_HI, ST_XSAT, ST_DIV, ST_MEAN, ST_SQ, ST_WB, ST_FIN_RD,
        ST_FIN_CALC, ST_SQRT, ST_FOUT
    } state_t;

    state_t state_reg;

    // Channel state memory, one entry per channel
    chan_state_t mem [CHANNEL_COUNT];
    chan_state_t rd_data_reg;
    logic        rd_ok_reg;
    logic [CHANNEL_COUNT-1:0] valid_reg;

    logic              mem_re, mem_we;
    logic [CH_W-1:0]   mem_raddr;
    chan_state_t       mem_wdata;
    chan_state_t       cur;

    // Item and working registers
    logic [1:0]        cmd_reg;
    logic [31:0]       stamp_reg;
    logic [CH_W-1:0]   idx_reg;
    logic [31:0]       ns_reg;
    chan_state_t       st_reg;
    logic [63:0]       ticks_reg;
    logic [63:0]       plo_reg;
    logic [63:0]       mul_p_reg;
    logic [47:0]       x_reg;
    logic [47:0]       absd_reg;
    logic [47:0]       absd2_reg;
    logic              neg_reg;
    logic [95:0]       acc_reg;
    logic [1:0]        sh_reg;
    logic [6:0]        cnt_reg;

    // Serial divider
    logic [31:0]       div_rem_reg;
    logic [63:0]       div_quo_reg;
    logic [31:0]       div_den_reg;

    // Square root
    logic [79:0]       sq_rad_reg;
    logic [41:0]       sq_rem_reg;
    logic [39:0]       sq_root_reg;

    logic              out_valid_reg;
    out_item_t         out_data_reg;

    // Combinational helpers
    logic [31:0] mul_a, mul_b;
    logic [63:0] ticks_c;
    logic [64:0] xsum_c;
    logic [47:0] x_c;
    logic [31:0] n_c;
    logic [32:0] div_sh_c;
    logic        div_ge_c;
    logic [43:0] sq_t_c;
    logic [43:0] sq_trial_c;
    logic [47:0] mean_new_c;
    logic [47:0] q_c;
    logic [63:0] prod_c;
    logic [64:0] m2_sum_c;
    logic [63:0] m2_new_c;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cur = rd_ok_reg ? rd_data_reg : CHAN_STATE_RESET;

    // Period in ticks, adding one wrap when the stamp went backwards unseen
    always_comb
    begin
        ticks_c = 64'(stamp_reg) + (64'(cur.wraps) << STAMP_BITS) - 64'(cur.prev_stamp);
        if (stamp_reg < cur.prev_stamp && cur.wraps == 32'd0)
        begin
            ticks_c = ticks_c + (64'd1 << STAMP_BITS);
        end
    end

    // Scaled period, saturated to 48 bits
    always_comb
    begin
        xsum_c = {1'b0, plo_reg} + {17'd0, mul_p_reg[15:0], 32'd0};
        if (mul_p_reg[63:16] != 48'd0 || xsum_c[64:48] != 17'd0)
        begin
            x_c = MAX48;
        end
        else
        begin
            x_c = xsum_c[47:0];
        end
        n_c = inc_sat(st_reg.periods);
    end

    assign div_sh_c   = {div_rem_reg, div_quo_reg[63]};
    assign div_ge_c   = (div_sh_c >= {1'b0, div_den_reg});
    assign sq_t_c     = {sq_rem_reg, sq_rad_reg[79:78]};
    assign sq_trial_c = {2'b00, sq_root_reg, 2'b01};

    assign q_c        = div_quo_reg[47:0];
    assign mean_new_c = neg_reg ? (st_reg.mean - q_c) : (st_reg.mean + q_c);

    always_comb
    begin
        prod_c   = (acc_reg[95:80] != 16'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_reg[79:16];
        m2_sum_c = {1'b0, st_reg.m2} + {1'b0, prod_c};
        m2_new_c = m2_sum_c[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum_c[63:0];
    end

    // Shared 32x32 multiplier operand selection
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            ST_MUL_LO:
            begin
                mul_a = ticks_reg[31:0];
                mul_b = ns_reg;
            end
            ST_MUL_HI:
            begin
                mul_a = ticks_reg[63:32];
                mul_b = ns_reg;
            end
            ST_SQ:
            begin
                mul_a = cnt_reg[0] ? 32'(absd_reg[47:24]) : 32'(absd_reg[23:0]);
                mul_b = cnt_reg[1] ? 32'(absd2_reg[47:24]) : 32'(absd2_reg[23:0]);
            end
            default:
            begin
                mul_a = 32'd0;
            end
        endcase
    end

    // Memory port control
    always_comb
    begin
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = idx_reg;
        mem_wdata = cur;
        unique case (state_reg)
            ST_OVF_RD, ST_EDGE_RD, ST_FIN_RD:
            begin
                mem_re = 1'b1;
            end
            ST_OVF_WR:
            begin
                mem_we              = 1'b1;
                mem_wdata.overflows = inc_sat(cur.overflows);
                mem_wdata.wraps     = inc_sat(cur.wraps);
            end
            ST_EDGE_CALC:
            begin
                mem_we               = !cur.have_prev;
                mem_wdata.edges      = inc_sat(cur.edges);
                mem_wdata.have_prev  = 1'b1;
                mem_wdata.prev_stamp = stamp_reg;
                mem_wdata.wraps      = 32'd0;
            end
            ST_WB:
            begin
                mem_we               = 1'b1;
                mem_wdata            = st_reg;
                mem_wdata.have_prev  = 1'b1;
                mem_wdata.prev_stamp = stamp_reg;
                mem_wdata.wraps      = 32'd0;
                mem_wdata.m2         = m2_new_c;
                mem_wdata.least      = (x_reg < st_reg.least) ? x_reg : st_reg.least;
                mem_wdata.greatest   = (x_reg > st_reg.greatest) ? x_reg : st_reg.greatest;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_raddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // Control, datapath registers and the report register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            rd_ok_reg     <= 1'b0;
            ns_reg        <= NS_PER_TICK_RESET;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            cmd_reg       <= CMD_OVERFLOW;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ns_reg <= cfg_data;
            end
            // In the report state a taken item is replaced there
            if (out_valid_reg && out_ready && state_reg != ST_FOUT)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mem_re)
            begin
                rd_ok_reg <= valid_reg[mem_raddr];
            end
            if (mem_we)
            begin
                valid_reg[mem_raddr] <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= in_data.cmd;
                        stamp_reg <= in_data.timestamp & STAMP_MASK;
                        idx_reg   <= (in_data.cmd == CMD_EDGE) ? CH_W'(in_data.channel) : '0;
                        priority if (in_data.cmd == CMD_OVERFLOW)
                        begin
                            state_reg <= ST_OVF_RD;
                        end
                        else if (in_data.cmd == CMD_EDGE)
                        begin
                            if (32'(in_data.channel) < CHANNEL_COUNT)
                            begin
                                state_reg <= ST_EDGE_RD;
                            end
                        end
                        else if (in_data.cmd == CMD_FINISH)
                        begin
                            state_reg <= ST_FIN_RD;
                        end
                        else
                        begin
                            // Unused command: drop the item
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_OVF_RD:
                begin
                    state_reg <= ST_OVF_WR;
                end
                ST_OVF_WR:
                begin
                    if (idx_reg == LAST_CH)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CH_W'(1);
                        state_reg <= ST_OVF_RD;
                    end
                end
                ST_EDGE_RD:
                begin
                    state_reg <= ST_EDGE_CALC;
                end
                ST_EDGE_CALC:
                begin
                    // Take the entry with its edge count already advanced
                    st_reg       <= mem_wdata;
                    ticks_reg    <= ticks_c;
                    state_reg    <= cur.have_prev ? ST_MUL_LO : ST_IDLE;
                end
                ST_MUL_LO:
                begin
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI:
                begin
                    plo_reg   <= mul_p_reg;
                    state_reg <= ST_XSAT;
                end
                ST_XSAT:
                begin
                    // Hold x, the new count and |x - mean|; start the mean divide
                    x_reg          <= x_c;
                    st_reg.periods <= n_c;
                    neg_reg        <= (x_c < st_reg.mean);
                    absd_reg       <= (x_c < st_reg.mean) ? (st_reg.mean - x_c)
                                                          : (x_c - st_reg.mean);
                    div_quo_reg    <= (x_c < st_reg.mean) ? 64'(st_reg.mean - x_c)
                                                          : 64'(x_c - st_reg.mean);
                    div_rem_reg    <= 32'd0;
                    div_den_reg    <= n_c;
                    cnt_reg        <= '0;
                    state_reg      <= ST_DIV;
                end
                ST_DIV:
                begin
                    div_rem_reg <= div_ge_c ? 32'(div_sh_c - {1'b0, div_den_reg})
                                            : div_sh_c[31:0];
                    div_quo_reg <= {div_quo_reg[62:0], div_ge_c};
                    if (cnt_reg == 7'd63)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (cmd_reg == CMD_FINISH) ? ST_SQRT : ST_MEAN;
                        sq_rad_reg  <= {div_quo_reg[62:0], div_ge_c, 16'd0};
                        sq_rem_reg  <= '0;
                        sq_root_reg <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                ST_MEAN:
                begin
                    st_reg.mean <= mean_new_c;
                    absd2_reg   <= (x_reg < mean_new_c) ? (mean_new_c - x_reg)
                                                        : (x_reg - mean_new_c);
                    acc_reg     <= '0;
                    cnt_reg     <= '0;
                    state_reg   <= ST_SQ;
                end
                ST_SQ:
                begin
                    // Issue one partial product, fold in the previous one
                    sh_reg  <= 2'(cnt_reg[0]) + 2'(cnt_reg[1]);
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg != 7'd0)
                    begin
                        acc_reg <= acc_reg + (96'(mul_p_reg) << (24 * sh_reg));
                    end
                    if (cnt_reg == 7'd4)
                    begin
                        state_reg <= ST_WB;
                    end
                end
                ST_WB:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_FIN_RD:
                begin
                    state_reg <= ST_FIN_CALC;
                end
                ST_FIN_CALC:
                begin
                    st_reg      <= cur;
                    sq_root_reg <= '0;
                    div_quo_reg <= cur.m2;
                    div_rem_reg <= 32'd0;
                    div_den_reg <= cur.periods - 32'd1;
                    cnt_reg     <= '0;
                    state_reg   <= (cur.periods > 32'd1) ? ST_DIV : ST_FOUT;
                end
                ST_SQRT:
                begin
                    sq_rad_reg <= {sq_rad_reg[77:0], 2'b00};
                    cnt_reg    <= cnt_reg + 7'd1;
                    if (sq_t_c >= sq_trial_c)
                    begin
                        sq_rem_reg  <= 42'(sq_t_c - sq_trial_c);
                        sq_root_reg <= {sq_root_reg[38:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg  <= sq_t_c[41:0];
                        sq_root_reg <= {sq_root_reg[38:0], 1'b0};
                    end
                    if (cnt_reg == 7'd39)
                    begin
                        state_reg <= ST_FOUT;
                    end
                end
                ST_FOUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.report_channel  <= idx_reg[0];
                        out_data_reg.edges_seen      <= st_reg.edges;
                        out_data_reg.overflows_seen  <= st_reg.overflows;
                        out_data_reg.periods_seen    <= st_reg.periods;
                        out_data_reg.min_period      <= (st_reg.periods == 32'd0) ? 48'd0
                                                                               : st_reg.least;
                        out_data_reg.max_period      <= (st_reg.periods == 32'd0) ? 48'd0
                                                                               : st_reg.greatest;
                        out_data_reg.mean_period     <= st_reg.mean;
                        out_data_reg.stddev_period   <= 48'(sq_root_reg);
                        out_data_reg.last            <= (idx_reg == LAST_REP);
                        if (idx_reg == LAST_REP)
                        begin
                            // Drop all channel state at once
                            valid_reg <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CH_W'(1);
                            state_reg <= ST_FIN_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.report_channel == 1'(NREP - 1))
        else $error("last report not on final channel");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> div_den_reg != 32'd0)
        else $error("divide by zero");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.periods_seen != 32'd0 |->
            out_data.min_period <= out_data.max_period)
        else $error("min period above max period");

    a_no_mem_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_re && mem_we))
        else $error("memory read and write in same cycle");

endmodule
